// File: sv/blg_pkg.sv
// ----------------------------------------------------------------------------
// blg_pkg: shared types and constants of the BLE link bridge guard
// Item layouts, link-state encoding, control opcodes and teardown reasons.
// ----------------------------------------------------------------------------
package blg_pkg;

    // Link state of one side, one-hot
    typedef enum logic [2:0] {
        ST_ADV  = 3'b001,
        ST_INIT = 3'b010,
        ST_DATA = 3'b100
    } t_link_st;

    // Reported state codes
    localparam logic [1:0] CODE_ADV  = 2'd0;
    localparam logic [1:0] CODE_INIT = 2'd1;
    localparam logic [1:0] CODE_DATA = 2'd2;

    // Teardown reasons
    localparam logic [2:0] RSN_NONE      = 3'd0;
    localparam logic [2:0] RSN_TERM_IND  = 3'd1;
    localparam logic [2:0] RSN_SUPERV    = 3'd2;
    localparam logic [2:0] RSN_INIT_TO   = 3'd3;
    localparam logic [2:0] RSN_RX_TO     = 3'd4;

    // Radio and header constants
    localparam logic [5:0] ADV_CH_FIRST        = 6'd37;
    localparam logic [1:0] LLID_CTRL           = 2'b11;
    localparam logic [3:0] ADV_TYPE_CONNECT    = 4'h5;
    localparam logic [7:0] CONN_IND_MIN_BYTES  = 8'd22;

    // Link-layer control opcodes
    localparam logic [7:0] OPC_CONN_UPDATE_IND = 8'h00;
    localparam logic [7:0] OPC_CHANNEL_MAP_IND = 8'h01;
    localparam logic [7:0] OPC_TERMINATE_IND   = 8'h02;
    localparam logic [7:0] OPC_FEATURE_REQ     = 8'h08;
    localparam logic [7:0] OPC_FEATURE_RSP     = 8'h09;
    localparam logic [7:0] OPC_PERIPH_FEAT_REQ = 8'h0E;
    localparam logic [7:0] OPC_CONN_PARAM_REQ  = 8'h0F;
    localparam logic [7:0] OPC_CONN_PARAM_RSP  = 8'h10;

    // Timer kinds
    localparam logic TMR_INIT = 1'b0;
    localparam logic TMR_RX   = 1'b1;

    localparam int TMR_W = 20;

    // One input item
    typedef struct packed {
        logic        req_type;
        logic        side_role;
        logic        is_rx;
        logic [5:0]  radio_channel;
        logic [7:0]  pdu_header;
        logic [7:0]  pdu_length;
        logic [7:0]  ctrl_opcode;
        logic [7:0]  win_size;
        logic [15:0] win_offset;
        logic [15:0] conn_interval;
        logic [15:0] supervision_to;
        logic [7:0]  payload_bytes;
    } t_req;

    // One result item
    typedef struct packed {
        logic       forward;
        logic       forward_dest;
        logic       downgrade_features;
        logic       send_conn_ind;
        logic       terminated;
        logic [2:0] term_reason;
        logic [1:0] periph_side_state;
        logic [1:0] central_side_state;
        logic       drain_to_peripheral;
        logic       drain_to_central;
    } t_res;

    function automatic logic [1:0] st_code(input t_link_st st);
        logic [1:0] code;
        unique case (st)
            ST_ADV:  code = CODE_ADV;
            ST_INIT: code = CODE_INIT;
            ST_DATA: code = CODE_DATA;
            default: code = CODE_ADV;
        endcase
        return code;
    endfunction

endpackage

// File: sv/ble_link_bridge_guard.sv
// ----------------------------------------------------------------------------
// ble_link_bridge_guard: link tracker and forward filter for a BLE relay
//
// Channel   Dir  Beat contents
// s_*       in   packet header fields or a 1 ms tick (tuser = req_type)
// m_*       out  forward decision, teardown report, side states
// cfg       in   rx_timeout_mult, write only
//
// One beat per cycle sustained while m_tready does not stall; each beat passes
// through the input register and then the result register.
// The side machines and the timer advance as a beat moves from the input
// register to the result register. A stall on m_tready holds the result and
// back-pressures s_tready only once the input register is also full.
// Reset is synchronous, active low; rx_timeout_mult resets to 40.
// ----------------------------------------------------------------------------
module ble_link_bridge_guard
    import blg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // side_role[0], is_rx[1], radio_channel[7:2], pdu_header[15:8],
    // pdu_length[23:16], ctrl_opcode[31:24], win_size[39:32],
    // win_offset[55:40], conn_interval[71:56], supervision_to[87:72],
    // payload_bytes[95:88]
    input  logic [95:0] s_tdata,
    // req_type[0]
    input  logic        s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // forward[0], forward_dest[1], downgrade_features[2], send_conn_ind[3],
    // terminated[4], term_reason[7:5], periph_side_state[9:8],
    // central_side_state[11:10], drain_to_peripheral[12],
    // drain_to_central[13], zero[15:14]
    output logic [15:0] m_tdata,
    // Configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam logic [7:0] RX_MULT_RESET = 8'd40;

    logic       r_in_valid;
    t_req       r_in;
    logic       r_out_valid;
    t_res       r_out;
    logic [7:0] r_rx_mult;
    logic       advance;
    logic       step;
    t_res       res;

    assign advance  = !r_out_valid || m_tready;
    assign step     = r_in_valid && advance;
    assign s_tready = !r_in_valid || advance;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_mult <= RX_MULT_RESET;
        end else if (i_cfg_we) begin
            r_rx_mult <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in.req_type       <= s_tuser;
            r_in.side_role      <= s_tdata[0];
            r_in.is_rx          <= s_tdata[1];
            r_in.radio_channel  <= s_tdata[7:2];
            r_in.pdu_header     <= s_tdata[15:8];
            r_in.pdu_length     <= s_tdata[23:16];
            r_in.ctrl_opcode    <= s_tdata[31:24];
            r_in.win_size       <= s_tdata[39:32];
            r_in.win_offset     <= s_tdata[55:40];
            r_in.conn_interval  <= s_tdata[71:56];
            r_in.supervision_to <= s_tdata[87:72];
            r_in.payload_bytes  <= s_tdata[95:88];
        end
    end

    blg_link u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_req     (r_in),
        .i_rx_mult (r_rx_mult),
        .o_res     (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00,
                       r_out.drain_to_central,
                       r_out.drain_to_peripheral,
                       r_out.central_side_state,
                       r_out.periph_side_state,
                       r_out.term_reason,
                       r_out.terminated,
                       r_out.send_conn_ind,
                       r_out.downgrade_features,
                       r_out.forward_dest,
                       r_out.forward};

endmodule

// File: sv/blg_link.sv
// ----------------------------------------------------------------------------
// blg_link: link tracker of the bridge guard
// Holds both side machines and the timer; computes one result per beat.
// ----------------------------------------------------------------------------
module blg_link
    import blg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_req       i_req,
    input  logic [7:0] i_rx_mult,
    output t_res       o_res
);

    t_link_st           r_p_st, n_p_st;
    t_link_st           r_c_st, n_c_st;
    logic [TMR_W-1:0]   r_tmr_cnt, n_tmr_cnt;
    logic [TMR_W-1:0]   r_tmr_rld, n_tmr_rld;
    logic               r_tmr_run, n_tmr_run;
    logic               r_tmr_kind, n_tmr_kind;
    logic [15:0]        r_sv_ival, n_sv_ival;
    logic [15:0]        r_sv_sup, n_sv_sup;

    logic               adv, ctl, term_ind, adv_connect, drop;
    logic [17:0]        init_sum;
    logic [19:0]        init_x5;
    logic [TMR_W-1:0]   init_load;
    logic [23:0]        rx_a;
    logic [19:0]        rx_b;
    logic [TMR_W-1:0]   rx_load;
    t_res               res;

    // Packet decode
    assign adv         = (i_req.radio_channel >= ADV_CH_FIRST);
    assign ctl         = !adv && (i_req.pdu_header[1:0] == LLID_CTRL);
    assign term_ind    = ctl && (i_req.ctrl_opcode == OPC_TERMINATE_IND);
    assign adv_connect = adv && (i_req.pdu_header[3:0] == ADV_TYPE_CONNECT);
    assign drop        = ctl && ((i_req.ctrl_opcode == OPC_CONN_UPDATE_IND) ||
                                 (i_req.ctrl_opcode == OPC_CHANNEL_MAP_IND) ||
                                 (i_req.ctrl_opcode == OPC_CONN_PARAM_REQ) ||
                                 (i_req.ctrl_opcode == OPC_CONN_PARAM_RSP) ||
                                 (i_req.ctrl_opcode == OPC_PERIPH_FEAT_REQ));

    // Initiation timeout: floor(5 * sum / 4)
    assign init_sum  = 18'(i_req.win_offset) + 18'(i_req.win_size)
                     + 18'(i_req.conn_interval) + 18'd1;
    assign init_x5   = 20'(init_sum) + {init_sum, 2'b00};
    assign init_load = TMR_W'(init_x5[19:2]);

    // Receive timeout: min(interval * mult, supervision * 10)
    assign rx_a    = 24'(r_sv_ival) * 24'(i_rx_mult);
    assign rx_b    = {1'b0, r_sv_sup, 3'b000} + {3'b000, r_sv_sup, 1'b0};
    assign rx_load = (rx_a < {4'b0000, rx_b}) ? rx_a[19:0] : rx_b;

    // Next state and result
    always_comb begin
        n_p_st     = r_p_st;
        n_c_st     = r_c_st;
        n_tmr_cnt  = r_tmr_cnt;
        n_tmr_rld  = r_tmr_rld;
        n_tmr_run  = r_tmr_run;
        n_tmr_kind = r_tmr_kind;
        n_sv_ival  = r_sv_ival;
        n_sv_sup   = r_sv_sup;
        res        = '0;

        if (i_req.req_type) begin
            // Millisecond tick: count down, expire at one or zero
            if (r_tmr_run) begin
                if (r_tmr_cnt <= TMR_W'(1)) begin
                    n_tmr_cnt       = '0;
                    res.terminated  = 1'b1;
                    res.term_reason = r_tmr_kind ? RSN_RX_TO : RSN_INIT_TO;
                    n_p_st          = ST_ADV;
                    n_c_st          = ST_ADV;
                    n_tmr_run       = 1'b0;
                end else begin
                    n_tmr_cnt = r_tmr_cnt - TMR_W'(1);
                end
            end
        end else begin
            // Forward decision from the packet; drain flags from the states before update
            if (i_req.is_rx && !adv && (i_req.pdu_length != 8'd0) && !drop) begin
                res.forward            = 1'b1;
                res.forward_dest       = i_req.side_role;
                res.downgrade_features = ctl && ((i_req.ctrl_opcode == OPC_FEATURE_REQ) ||
                                                 (i_req.ctrl_opcode == OPC_FEATURE_RSP));
            end
            res.drain_to_peripheral = (r_c_st == ST_DATA);
            res.drain_to_central    = (r_p_st == ST_DATA);

            if (!i_req.side_role) begin
                // Peripheral-facing radio
                unique case (r_p_st)
                    ST_ADV: begin
                        if (i_req.is_rx && adv_connect &&
                            (i_req.payload_bytes >= CONN_IND_MIN_BYTES)) begin
                            n_p_st     = ST_INIT;
                            n_sv_ival  = i_req.conn_interval;
                            n_sv_sup   = i_req.supervision_to;
                            n_tmr_rld  = init_load;
                            n_tmr_cnt  = init_load;
                            n_tmr_run  = 1'b1;
                            n_tmr_kind = TMR_INIT;
                        end
                    end
                    ST_INIT: begin
                        if (!adv) begin
                            n_p_st            = ST_DATA;
                            res.send_conn_ind = 1'b1;
                            n_tmr_rld         = rx_load;
                            n_tmr_cnt         = rx_load;
                            n_tmr_run         = 1'b1;
                            n_tmr_kind        = TMR_RX;
                        end
                    end
                    ST_DATA: begin
                        // Restart the receive timer on any received beat
                        if (i_req.is_rx) begin
                            n_tmr_cnt = r_tmr_rld;
                            n_tmr_run = 1'b1;
                        end
                        if (term_ind || adv) begin
                            res.terminated  = 1'b1;
                            res.term_reason = term_ind ? RSN_TERM_IND : RSN_SUPERV;
                            n_p_st          = ST_ADV;
                            n_c_st          = ST_ADV;
                            n_tmr_run       = 1'b0;
                        end
                    end
                    default: begin
                        n_p_st = ST_ADV;
                    end
                endcase
            end else begin
                // Central-facing radio
                unique case (r_c_st)
                    ST_ADV: begin
                        if (!i_req.is_rx && adv_connect) begin
                            n_c_st = ST_INIT;
                        end
                    end
                    ST_INIT: begin
                        if (!adv) begin
                            n_c_st = ST_DATA;
                        end
                    end
                    ST_DATA: begin
                        if (term_ind) begin
                            res.terminated  = 1'b1;
                            res.term_reason = RSN_TERM_IND;
                            n_p_st          = ST_ADV;
                            n_c_st          = ST_ADV;
                            n_tmr_run       = 1'b0;
                        end
                    end
                    default: begin
                        n_c_st = ST_ADV;
                    end
                endcase
            end
        end

        res.periph_side_state  = st_code(n_p_st);
        res.central_side_state = st_code(n_c_st);
    end

    assign o_res = res;

    // Advance the tracker once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_st     <= ST_ADV;
            r_c_st     <= ST_ADV;
            r_tmr_cnt  <= '0;
            r_tmr_rld  <= '0;
            r_tmr_run  <= 1'b0;
            r_tmr_kind <= TMR_INIT;
            r_sv_ival  <= '0;
            r_sv_sup   <= '0;
        end else if (i_step) begin
            r_p_st     <= n_p_st;
            r_c_st     <= n_c_st;
            r_tmr_cnt  <= n_tmr_cnt;
            r_tmr_rld  <= n_tmr_rld;
            r_tmr_run  <= n_tmr_run;
            r_tmr_kind <= n_tmr_kind;
            r_sv_ival  <= n_sv_ival;
            r_sv_sup   <= n_sv_sup;
        end
    end

endmodule
